>>> rtl/rational_fraction_alu_core_defines.svh
// Assertion macros shared by the rational fraction ALU.
`ifndef RATIONAL_FRACTION_ALU_CORE_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_CORE_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define RFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational fraction ALU check failed");

// Checks a consequent in the cycle after its antecedent.
`define RFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational fraction ALU check failed");

`endif

>>> rtl/rfa_pkg.sv
// Shared codes and controller/datapath interface types for the fraction ALU.
`timescale 1ns / 1ps
package rfa_pkg;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  localparam logic [1:0] MUL_NUM_A = 2'd0;
  localparam logic [1:0] MUL_NUM_B = 2'd1;
  localparam logic [1:0] MUL_DEN   = 2'd2;

  localparam logic [1:0] DIV_EUCLID = 2'd0;
  localparam logic [1:0] DIV_NUM    = 2'd1;
  localparam logic [1:0] DIV_DEN    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       combine;
    logic       div_go;
    logic [1:0] div_src;
    logic       gcd_step;
    logic       take_qn;
    logic       take_qd;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       y_zero;
    logic [1:0] err;
  } sts_t;

endpackage

>>> rtl/rfa_datapath.sv
// Datapath: operand registers, shared multiplier, Euclid registers and a radix-2 divider.
`timescale 1ns / 1ps
module rfa_datapath #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfa_pkg::cmd_t        cmd,
  output rfa_pkg::sts_t        sts,
  input  logic [1:0]           in_mode,
  input  logic signed [W-1:0]  in_a_num,
  input  logic signed [W-1:0]  in_a_den,
  input  logic signed [W-1:0]  in_b_num,
  input  logic signed [W-1:0]  in_b_den,
  output logic                 out_valid,
  output logic signed [32:0]   out_res_num,
  output logic [30:0]          out_res_den,
  output logic [1:0]           out_status
);

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NW = (SW > 64) ? 64 : SW;
  localparam int CW = $clog2(NW);
  localparam int RW = (NW > 33) ? NW : 33;
  localparam int DW = (NW > 31) ? NW : 31;
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

  logic [1:0]          mode_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0] p0_r, p1_r, den_r;
  logic signed [NW-1:0] num_r;
  logic [NW-1:0] mn_r, md_r, x_r, y_r, qn_r, qd_r;
  logic [NW-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          out_valid_r;
  logic signed [32:0] out_num_r;
  logic [30:0]   out_den_r;
  logic [1:0]    out_status_r;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] product;
  logic signed [SW-1:0] sum;
  logic signed [NW-1:0] num_nxt;
  logic [NW-1:0] num_mag, den_mag, gcd_val, div_dnd, div_dvs;
  logic [PW-1:0] den_abs;
  logic [NW:0]   shifted, trial;
  logic          neg;
  logic [RW-1:0] num_ext;
  logic [DW-1:0] den_ext;
  logic [1:0]    err;

  // A zero denominator takes precedence over a zero divisor fraction.
  always_comb begin
    if (ad_r == '0 || bd_r == '0) begin
      err = rfa_pkg::ST_ZERO_DEN;
    end else if (mode_r == rfa_pkg::MODE_DIV && bn_r == '0) begin
      err = rfa_pkg::ST_DIV_ZERO;
    end else begin
      err = rfa_pkg::ST_OK;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      rfa_pkg::MUL_NUM_A: begin
        mul_a = an_r;
        mul_b = (mode_r == rfa_pkg::MODE_MUL) ? bn_r : bd_r;
      end
      rfa_pkg::MUL_NUM_B: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (mode_r == rfa_pkg::MODE_DIV) ? bn_r : bd_r;
      end
    endcase
    product = PW'(mul_a * mul_b);
  end

  always_comb begin
    case (mode_r)
      rfa_pkg::MODE_ADD: sum = SW'(p0_r) + SW'(p1_r);
      rfa_pkg::MODE_SUB: sum = SW'(p0_r) - SW'(p1_r);
      default:           sum = SW'(p0_r);
    endcase
    num_nxt = sum[NW-1:0];
    num_mag = num_nxt[NW-1] ? NW'(-num_nxt) : NW'(num_nxt);
    den_abs = den_r[PW-1] ? PW'(-den_r) : PW'(den_r);
    den_mag = NW'(den_abs);
  end

  assign gcd_val = (x_r == '0) ? NW'(1) : x_r;

  always_comb begin
    case (cmd.div_src)
      rfa_pkg::DIV_EUCLID: begin
        div_dnd = x_r;
        div_dvs = y_r;
      end
      rfa_pkg::DIV_NUM: begin
        div_dnd = mn_r;
        div_dvs = gcd_val;
      end
      default: begin
        div_dnd = md_r;
        div_dvs = gcd_val;
      end
    endcase
  end

  // One restoring step a cycle; the partial remainder stays below the divisor.
  assign shifted = {rem_r, quo_r[NW-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  assign neg     = (qn_r != '0) && (num_r[NW-1] != den_r[PW-1]);
  assign num_ext = neg ? RW'(-qn_r) : RW'(qn_r);
  assign den_ext = (qn_r == '0) ? DW'(1) : DW'(qd_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      an_r   <= in_a_num;
      ad_r   <= in_a_den;
      bn_r   <= in_b_num;
      bd_r   <= in_b_den;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rfa_pkg::MUL_NUM_A: p0_r <= product;
        rfa_pkg::MUL_NUM_B: p1_r <= product;
        default:            den_r <= product;
      endcase
    end
    if (cmd.combine) begin
      num_r <= num_nxt;
      mn_r  <= num_mag;
      md_r  <= den_mag;
      x_r   <= num_mag;
      y_r   <= den_mag;
    end
    if (cmd.gcd_step) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
    if (cmd.take_qn) qn_r <= quo_r;
    if (cmd.take_qd) qd_r <= quo_r;
    if (cmd.div_go) begin
      rem_r <= '0;
      quo_r <= div_dnd;
      dvs_r <= div_dvs;
    end else if (run_r) begin
      if (!trial[NW]) begin
        rem_r <= trial[NW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[NW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      if (err != rfa_pkg::ST_OK) begin
        out_num_r <= '0;
        out_den_r <= 31'd1;
      end else begin
        out_num_r <= num_ext[32:0];
        out_den_r <= den_ext[30:0];
      end
      out_status_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.div_go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) run_r <= 1'b0;
      end
    end
  end

  assign sts.div_done = run_r && (cnt_r == LAST_STEP);
  assign sts.y_zero   = (y_r == '0);
  assign sts.err      = err;

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_status_r;

endmodule

>>> rtl/rfa_ctrl.sv
// Controller state machine sequencing products, Euclid steps and the final divisions.
`timescale 1ns / 1ps
module rfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rfa_pkg::sts_t sts,
  output rfa_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MULA  = 4'd2;
  localparam logic [3:0] S_MULB  = 4'd3;
  localparam logic [3:0] S_MULD  = 4'd4;
  localparam logic [3:0] S_COMB  = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_GWAIT = 4'd7;
  localparam logic [3:0] S_GSTEP = 4'd8;
  localparam logic [3:0] S_NWAIT = 4'd9;
  localparam logic [3:0] S_NTAKE = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;
  localparam logic [3:0] S_DTAKE = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err != rfa_pkg::ST_OK) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rfa_pkg::MUL_NUM_A;
        state_nxt   = S_MULB;
      end
      S_MULB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rfa_pkg::MUL_NUM_B;
        state_nxt   = S_MULD;
      end
      S_MULD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rfa_pkg::MUL_DEN;
        state_nxt   = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt   = S_GCD;
      end
      S_GCD: begin
        // Once the remainder is zero the gcd sits in x and the numerator is divided.
        cmd.div_go = 1'b1;
        if (sts.y_zero) begin
          cmd.div_src = rfa_pkg::DIV_NUM;
          state_nxt   = S_NWAIT;
        end else begin
          cmd.div_src = rfa_pkg::DIV_EUCLID;
          state_nxt   = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (sts.div_done) state_nxt = S_GSTEP;
      end
      S_GSTEP: begin
        cmd.gcd_step = 1'b1;
        state_nxt    = S_GCD;
      end
      S_NWAIT: begin
        if (sts.div_done) state_nxt = S_NTAKE;
      end
      S_NTAKE: begin
        cmd.take_qn = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_src = rfa_pkg::DIV_DEN;
        state_nxt   = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) state_nxt = S_DTAKE;
      end
      S_DTAKE: begin
        // The last divider step has landed, so the quotient is complete here.
        cmd.take_qd = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/rational_fraction_alu_core.sv
// Top level of the rational fraction ALU: controller, datapath and checks.
//
//  Channel  Ports                                   Handshake
//  input    in_mode, in_a_num/den, in_b_num/den     start high while busy low
//  result   out_res_num, out_res_den, out_status    out_valid high for one cycle
//
// With a zero denominator or a zero divisor fraction the controller emits the zero result
// from its check state and skips the arithmetic. Otherwise the result follows three products,
// the Euclid divisions by a nonzero value and two final divisions, each division taking
// N = min(2W+1, 64) steps of the one shared radix-2 divider. busy falls as the strobe rises.
// Reset is synchronous and returns the controller to idle with no result pending.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "rational_fraction_alu_core_defines.svh"
module rational_fraction_alu_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_mode,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  output logic signed [32:0]              out_res_num,
  output logic [30:0]                     out_res_den,
  output logic [1:0]                      out_status
);

  rfa_pkg::cmd_t cmd;
  rfa_pkg::sts_t sts;

  logic err_out;
  logic err_zero;

  rfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rfa_datapath #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_mode),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_valid   (out_valid),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

  assign err_out  = out_valid && (out_status != rfa_pkg::ST_OK);
  assign err_zero = (out_res_num == 33'sd0) && (out_res_den == 31'd1);

  `RFA_ASSERT_NOW(a_den_nonzero, out_valid, out_res_den != 31'd0)
  `RFA_ASSERT_NOW(a_err_zero_result, err_out, err_zero)
  `RFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RFA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

endmodule
